// File: sv/lldv_pkg.sv
package lldv_pkg;

  // fixed field widths of the request and response, and of the microprogram counter
  localparam int unsigned IDX_W = 4;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned UPC_W = 4;

  typedef enum logic [1:0] {
    CMD_LOAD_NODE = 2'd0,
    CMD_SET_HEADS = 2'd1,
    CMD_DELETE    = 2'd2,
    CMD_READ_NODE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DELETED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e               command;
    logic [IDX_W-1:0]   node_index;
    logic [VAL_W-1:0]   item_value;
    logic [IDX_W-1:0]   next_link;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [IDX_W-1:0]   found_index;
    logic [IDX_W-1:0]   prev_index;
    logic [VAL_W-1:0]   node_value;
    logic [IDX_W-1:0]   node_link;
    logic [IDX_W-1:0]   head_out;
    logic [IDX_W-1:0]   free_head_out;
  } rsp_t;

  // control word fields
  typedef enum logic {
    ADDR_IDX = 1'b0,
    ADDR_CUR = 1'b1
  } addr_sel_e;

  typedef enum logic [1:0] {
    LW_NONE   = 2'd0,
    LW_LOAD   = 2'd1,
    LW_BYPASS = 2'd2,
    LW_PUSH   = 2'd3
  } lnk_wsel_e;

  typedef enum logic [1:0] {
    HD_KEEP   = 2'd0,
    HD_SET    = 2'd1,
    HD_UNLINK = 2'd2
  } head_op_e;

  typedef enum logic [1:0] {
    FR_KEEP = 2'd0,
    FR_SET  = 2'd1,
    FR_PUSH = 2'd2
  } free_op_e;

  typedef enum logic [1:0] {
    WK_NONE = 2'd0,
    WK_INIT = 2'd1,
    WK_ADV  = 2'd2
  } walk_op_e;

  typedef enum logic [1:0] {
    C_ALWAYS    = 2'd0,
    C_HEAD_ZERO = 2'd1,
    C_WALK_END  = 2'd2,
    C_MISS      = 2'd3
  } cond_e;

  typedef enum logic [1:0] {
    OUT_PLAIN = 2'd0,
    OUT_READ  = 2'd1,
    OUT_DEL   = 2'd2
  } out_sel_e;

  typedef struct packed {
    logic               rd_en;
    addr_sel_e          addr_sel;
    logic               val_we;
    lnk_wsel_e          lnk_wsel;
    head_op_e           head_op;
    free_op_e           free_op;
    walk_op_e           walk_op;
    logic               jump;
    cond_e              cond;
    logic [UPC_W-1:0]   target;
    logic               emit;
    status_e            status;
    out_sel_e           out_sel;
  } ucw_t;

  // node store control between sequencer and store
  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               val_we;
    logic [IDX_W-1:0]   val_addr;
    logic               lnk_we;
    logic [IDX_W-1:0]   lnk_addr;
    logic [IDX_W-1:0]   lnk_wdata;
  } store_ctl_t;

  // microprogram addresses
  localparam logic [UPC_W-1:0] UA_IDLE     = 4'd0;
  localparam logic [UPC_W-1:0] UA_LOAD     = 4'd1;
  localparam logic [UPC_W-1:0] UA_SETH     = 4'd2;
  localparam logic [UPC_W-1:0] UA_SETH_OUT = 4'd3;
  localparam logic [UPC_W-1:0] UA_READ     = 4'd4;
  localparam logic [UPC_W-1:0] UA_READ_OUT = 4'd5;
  localparam logic [UPC_W-1:0] UA_DEL      = 4'd6;
  localparam logic [UPC_W-1:0] UA_WALK_RD  = 4'd7;
  localparam logic [UPC_W-1:0] UA_WALK_CMP = 4'd8;
  localparam logic [UPC_W-1:0] UA_HIT0     = 4'd9;
  localparam logic [UPC_W-1:0] UA_HIT1     = 4'd10;
  localparam logic [UPC_W-1:0] UA_DEL_OUT  = 4'd11;
  localparam logic [UPC_W-1:0] UA_NF_OUT   = 4'd12;
  localparam logic [UPC_W-1:0] UA_UF_OUT   = 4'd13;

  localparam ucw_t UCW_NOP = '{
    rd_en: 1'b0, addr_sel: ADDR_IDX, val_we: 1'b0, lnk_wsel: LW_NONE,
    head_op: HD_KEEP, free_op: FR_KEEP, walk_op: WK_NONE,
    jump: 1'b0, cond: C_ALWAYS, target: UA_IDLE,
    emit: 1'b0, status: ST_DONE, out_sel: OUT_PLAIN
  };

  // entry point of each command
  function automatic logic [UPC_W-1:0] entry(cmd_e cmd);
    logic [UPC_W-1:0] ua;
    case (cmd)
      CMD_LOAD_NODE: ua = UA_LOAD;
      CMD_SET_HEADS: ua = UA_SETH;
      CMD_DELETE:    ua = UA_DEL;
      CMD_READ_NODE: ua = UA_READ;
      default:       ua = UA_IDLE;
    endcase
    return ua;
  endfunction

  // control store
  function automatic ucw_t ucode(logic [UPC_W-1:0] upc);
    ucw_t cw;
    cw = UCW_NOP;
    case (upc)
      UA_LOAD: begin
        cw.val_we   = 1'b1;
        cw.lnk_wsel = LW_LOAD;
        cw.emit     = 1'b1;
        cw.jump     = 1'b1;
      end
      UA_SETH: begin
        cw.head_op = HD_SET;
        cw.free_op = FR_SET;
      end
      UA_SETH_OUT: begin
        cw.emit = 1'b1;
        cw.jump = 1'b1;
      end
      UA_READ: begin
        cw.rd_en = 1'b1;
      end
      UA_READ_OUT: begin
        cw.emit    = 1'b1;
        cw.out_sel = OUT_READ;
        cw.jump    = 1'b1;
      end
      UA_DEL: begin
        cw.walk_op = WK_INIT;
        cw.jump    = 1'b1;
        cw.cond    = C_HEAD_ZERO;
        cw.target  = UA_UF_OUT;
      end
      UA_WALK_RD: begin
        cw.rd_en    = 1'b1;
        cw.addr_sel = ADDR_CUR;
        cw.jump     = 1'b1;
        cw.cond     = C_WALK_END;
        cw.target   = UA_NF_OUT;
      end
      UA_WALK_CMP: begin
        cw.walk_op = WK_ADV;
        cw.jump    = 1'b1;
        cw.cond    = C_MISS;
        cw.target  = UA_WALK_RD;
      end
      UA_HIT0: begin
        cw.head_op  = HD_UNLINK;
        cw.lnk_wsel = LW_BYPASS;
      end
      UA_HIT1: begin
        cw.lnk_wsel = LW_PUSH;
        cw.free_op  = FR_PUSH;
      end
      UA_DEL_OUT: begin
        cw.emit    = 1'b1;
        cw.status  = ST_DELETED;
        cw.out_sel = OUT_DEL;
        cw.jump    = 1'b1;
      end
      UA_NF_OUT: begin
        cw.emit   = 1'b1;
        cw.status = ST_NOT_FOUND;
        cw.jump   = 1'b1;
      end
      UA_UF_OUT: begin
        cw.emit   = 1'b1;
        cw.status = ST_UNDERFLOW;
        cw.jump   = 1'b1;
      end
      default: begin
        cw.jump = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

// File: sv/lldv_node_store.sv
module lldv_node_store #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lldv_pkg::store_ctl_t     ctl_i,
  input  logic [VALUE_WIDTH-1:0]   val_wdata_i,
  output logic [VALUE_WIDTH-1:0]   val_rd_o,
  output logic [lldv_pkg::IDX_W-1:0] lnk_rd_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [VALUE_WIDTH-1:0]       val_mem [DEPTH];
  logic [lldv_pkg::IDX_W-1:0]   lnk_mem [DEPTH];
  logic [DEPTH-1:0]             lnk_vld_q;
  logic [VALUE_WIDTH-1:0]       val_rd_q;
  logic [lldv_pkg::IDX_W-1:0]   lnk_rd_q;

  logic [AW-1:0] rd_a, val_a, lnk_a;

  assign rd_a  = ctl_i.rd_addr[AW-1:0];
  assign val_a = ctl_i.val_addr[AW-1:0];
  assign lnk_a = ctl_i.lnk_addr[AW-1:0];

  // value store, no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.val_we) begin
      val_mem[val_a] <= val_wdata_i;
    end
    if (ctl_i.rd_en) begin
      val_rd_q <= val_mem[rd_a];
    end
  end

  // link store, unwritten entries read as zero
  always_ff @(posedge clk_i) begin
    if (ctl_i.lnk_we) begin
      lnk_mem[lnk_a] <= ctl_i.lnk_wdata;
    end
    if (ctl_i.rd_en) begin
      lnk_rd_q <= lnk_vld_q[rd_a] ? lnk_mem[rd_a] : '0;
    end
  end

  // per-entry written flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lnk_vld_q <= '0;
    end else if (ctl_i.lnk_we) begin
      lnk_vld_q[lnk_a] <= 1'b1;
    end
  end

  assign val_rd_o = val_rd_q;
  assign lnk_rd_o = lnk_rd_q;

endmodule

// File: sv/linked_list_delete_by_value_unit.sv
// load_node writes the node; set_heads sets both heads and read_node reads the node
// store before the result; delete on an empty list reports underflow; a delete that
// visits k nodes (k at most NODE_COUNT) reports not found when the value is absent and
// removes the k-th node on a match; each node walked takes a node store read, then the
// compare and advance. One request at a time; busy drops in the cycle done_o is high,
// so the next start can be taken there. Results show for one cycle and cannot be held off.
// Reset clears both heads and all links (per-entry flags); node values stay unknown.
module linked_list_delete_by_value_unit #(
  parameter int unsigned NODE_COUNT  = 16,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  lldv_pkg::req_t  req_i,
  output logic            done_o,
  output lldv_pkg::rsp_t  rsp_o
);

  // only slots reachable by a 4-bit index are stored
  localparam int unsigned DEPTH = (NODE_COUNT < (1 << lldv_pkg::IDX_W)) ?
                                  NODE_COUNT : (1 << lldv_pkg::IDX_W);
  localparam int unsigned SW = $clog2(NODE_COUNT + 1);
  localparam int unsigned IW = lldv_pkg::IDX_W;

  logic [lldv_pkg::UPC_W-1:0] upc_q, upc_d;
  lldv_pkg::ucw_t             cw;

  logic [IW-1:0]          idx_q, nlink_q, cur_q, cur_d, before_q, before_d;
  logic [IW-1:0]          head_q, head_d, free_q, free_d;
  logic [VALUE_WIDTH-1:0] item_q;
  logic [SW-1:0]          steps_q, steps_d;
  logic                   done_q;
  lldv_pkg::rsp_t         rsp_q, rsp_d;

  lldv_pkg::store_ctl_t   sctl;
  logic [VALUE_WIDTH-1:0] val_rd;
  logic [IW-1:0]          lnk_rd;

  logic        accept, idx_ok, match, walk_end, take;
  logic [63:0] item_ext, val_ext;

  assign accept   = start && !busy;
  assign busy     = (upc_q != lldv_pkg::UA_IDLE);
  assign cw       = lldv_pkg::ucode(upc_q);
  assign item_ext = 64'(req_i.item_value);
  assign val_ext  = 64'(val_rd);

  assign idx_ok   = (32'(idx_q) < DEPTH);
  assign match    = (val_rd == item_q);
  assign walk_end = (cur_q == '0) || (32'(cur_q) >= NODE_COUNT) ||
                    (steps_q == SW'(NODE_COUNT));

  // jump condition
  always_comb begin
    case (cw.cond)
      lldv_pkg::C_ALWAYS:    take = 1'b1;
      lldv_pkg::C_HEAD_ZERO: take = (head_q == '0);
      lldv_pkg::C_WALK_END:  take = walk_end;
      lldv_pkg::C_MISS:      take = !match;
      default:               take = 1'b0;
    endcase
  end

  // microprogram counter, next address
  always_comb begin
    if (upc_q == lldv_pkg::UA_IDLE) begin
      upc_d = accept ? lldv_pkg::entry(req_i.command) : lldv_pkg::UA_IDLE;
    end else if (cw.jump && take) begin
      upc_d = cw.target;
    end else begin
      upc_d = upc_q + 1'b1;
    end
  end

  // node store control
  always_comb begin
    sctl.rd_en     = cw.rd_en;
    sctl.rd_addr   = (cw.addr_sel == lldv_pkg::ADDR_IDX) ? idx_q : cur_q;
    sctl.val_we    = cw.val_we && idx_ok;
    sctl.val_addr  = idx_q;
    case (cw.lnk_wsel)
      lldv_pkg::LW_LOAD: begin
        sctl.lnk_we    = idx_ok;
        sctl.lnk_addr  = idx_q;
        sctl.lnk_wdata = nlink_q;
      end
      lldv_pkg::LW_BYPASS: begin
        sctl.lnk_we    = (before_q != '0);
        sctl.lnk_addr  = before_q;
        sctl.lnk_wdata = lnk_rd;
      end
      lldv_pkg::LW_PUSH: begin
        sctl.lnk_we    = 1'b1;
        sctl.lnk_addr  = cur_q;
        sctl.lnk_wdata = free_q;
      end
      default: begin
        sctl.lnk_we    = 1'b0;
        sctl.lnk_addr  = cur_q;
        sctl.lnk_wdata = free_q;
      end
    endcase
  end

  // heads and walk registers
  always_comb begin
    head_d   = head_q;
    free_d   = free_q;
    cur_d    = cur_q;
    before_d = before_q;
    steps_d  = steps_q;
    case (cw.head_op)
      lldv_pkg::HD_SET:    head_d = idx_q;
      lldv_pkg::HD_UNLINK: head_d = (before_q == '0) ? lnk_rd : head_q;
      default:             head_d = head_q;
    endcase
    case (cw.free_op)
      lldv_pkg::FR_SET:  free_d = nlink_q;
      lldv_pkg::FR_PUSH: free_d = cur_q;
      default:           free_d = free_q;
    endcase
    case (cw.walk_op)
      lldv_pkg::WK_INIT: begin
        cur_d    = head_q;
        before_d = '0;
        steps_d  = '0;
      end
      lldv_pkg::WK_ADV: begin
        if (!match) begin
          before_d = cur_q;
          cur_d    = lnk_rd;
          steps_d  = steps_q + 1'b1;
        end
      end
      default: begin
        cur_d = cur_q;
      end
    endcase
  end

  // response word
  always_comb begin
    rsp_d               = '0;
    rsp_d.status        = cw.status;
    rsp_d.head_out      = head_q;
    rsp_d.free_head_out = free_q;
    case (cw.out_sel)
      lldv_pkg::OUT_READ: begin
        rsp_d.found_index = idx_q;
        if (idx_ok) begin
          rsp_d.node_value = val_ext[lldv_pkg::VAL_W-1:0];
          rsp_d.node_link  = lnk_rd;
        end
      end
      lldv_pkg::OUT_DEL: begin
        rsp_d.found_index = cur_q;
        rsp_d.prev_index  = before_q;
      end
      default: begin
        rsp_d.found_index = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q    <= lldv_pkg::UA_IDLE;
      head_q   <= '0;
      free_q   <= '0;
      done_q   <= 1'b0;
      steps_q  <= '0;
    end else begin
      upc_q    <= upc_d;
      head_q   <= head_d;
      free_q   <= free_d;
      done_q   <= cw.emit;
      steps_q  <= steps_d;
    end
  end

  // request capture, walk pointers and response register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q   <= req_i.node_index;
      nlink_q <= req_i.next_link;
      item_q  <= item_ext[VALUE_WIDTH-1:0];
    end
    cur_q    <= cur_d;
    before_q <= before_d;
    if (cw.emit) begin
      rsp_q <= rsp_d;
    end
  end

  lldv_node_store #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (sctl),
    .val_wdata_i (item_q),
    .val_rd_o    (val_rd),
    .lnk_rd_o    (lnk_rd)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // a result only follows a cycle of work
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a request in progress");

  // an accepted request always starts the sequencer
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not start the sequencer");

  // a deleted node is never the null slot
  a_del_nonnull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == lldv_pkg::ST_DELETED) |-> (rsp_o.found_index != '0))
    else $error("deleted null node");

  // the walk never goes past the node count
  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(steps_q) <= NODE_COUNT)
    else $error("walk exceeded node count");

endmodule
